// ===== design/versioned_block_stream_framer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Versioned block stream framer: assertion macros
// Shared property shorthands; every use expects i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef VERSIONED_BLOCK_STREAM_FRAMER_UNIT_DEFINES_SVH
`define VERSIONED_BLOCK_STREAM_FRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define VBSF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define VBSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// vbsf_pkg
// Types, constants and CRC helpers shared by the block stream framer.
// ----------------------------------------------------------------------------
package vbsf_pkg;

    // Default geometry
    localparam int unsigned DATA_BYTES_PER_BLOCK_DEF = 60;
    localparam int unsigned NUM_BLOCKS_DEF           = 64;

    // Field widths
    localparam int unsigned LEN_W        = 11;
    localparam int unsigned VER_W        = 16;
    localparam int unsigned START_W      = 6;
    localparam int unsigned START_BLOCKS = 1 << START_W;
    localparam int unsigned BIDX_W       = 6;
    localparam int unsigned WIDX_W       = 4;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned S_TDATA_W    = 8;
    localparam int unsigned M_FIELDS_W   = BIDX_W + WIDX_W + WORD_W;
    localparam int unsigned M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_PAD_W      = M_TDATA_W - M_FIELDS_W;
    localparam int unsigned CFG_ADDR_W   = 2;
    localparam int unsigned CFG_DATA_W   = 16;
    // block byte position; holds DATA_BYTES_PER_BLOCK + 3 for any block size up to 252
    localparam int unsigned POS_W        = 8;

    // CRC constants
    localparam logic [15:0] CRC16_POLY = 16'h1021;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC32_INIT = 32'hFFFFFFFF;

    // Length header counts itself and the trailing CRC-32
    localparam logic [LEN_W:0] FRAME_OVERHEAD = (LEN_W + 1)'(8);

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PAYLOAD_LENGTH = 2'd0,
        CFG_STREAM_VERSION = 2'd1,
        CFG_START_BLOCK    = 2'd2
    } t_cfg_reg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_ERROR
    } t_state;

    // Origin of the stream byte being placed
    typedef enum logic [3:0] {
        SRC_HDR0,
        SRC_HDR1,
        SRC_HDR2,
        SRC_HDR3,
        SRC_DATA,
        SRC_CRC0,
        SRC_CRC1,
        SRC_CRC2,
        SRC_CRC3,
        SRC_PAD
    } t_src;

    // Part of the block the current byte fills
    typedef enum logic [2:0] {
        PH_VER_HI,
        PH_VER_LO,
        PH_BYTE,
        PH_CRC_HI,
        PH_CRC_LO
    } t_phase;

    // Controller to datapath
    typedef struct packed {
        logic             load;        // latch the accepted item
        logic             step;        // place one block byte
        t_src             src;
        t_phase           phase;
        logic [POS_W-1:0] pos;         // byte offset inside the block
        logic             emit;        // this byte completes a word
        logic             eos;         // word is the last of the stream
        logic             err;         // emit the too-large result
        logic             stream_end;  // return stream state to reset
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [LEN_W-1:0] eff_len;
        logic             too_large;
        logic             out_free;
    } t_dp_stat;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
        end
        return c;
    endfunction

    // CRC-32 reflected, one byte, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/vbsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// vbsf_ctrl
// Sequencer: walks header, payload, CRC-32 and padding bytes through the block
// layout, one block byte per cycle unless output is full; counts stream bytes.
// ----------------------------------------------------------------------------
`include "versioned_block_stream_framer_unit_defines.svh"

module vbsf_ctrl import vbsf_pkg::*; #(
    parameter int unsigned DATA_BYTES_PER_BLOCK = DATA_BYTES_PER_BLOCK_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam int unsigned OFF_W = $clog2(DATA_BYTES_PER_BLOCK);
    localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(DATA_BYTES_PER_BLOCK + 2);
    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(DATA_BYTES_PER_BLOCK + 3);
    localparam logic [OFF_W-1:0] OFF_LAST   = OFF_W'(DATA_BYTES_PER_BLOCK - 1);

    t_state           r_state,  n_state;
    t_src             r_src,    n_src;
    t_phase           r_phase,  n_phase;
    logic [OFF_W-1:0] r_offset, n_offset;
    logic [LEN_W-1:0] r_count,  n_count;
    logic             r_failed, n_failed;
    logic             r_end,    n_end;

    logic [POS_W-1:0] w_pos;
    logic             w_emit;
    logic             w_full;
    logic [OFF_W-1:0] w_off_new;
    logic [LEN_W:0]   w_cnt_inc;
    logic             w_cnt_end;
    t_src             w_adv_src;
    logic             w_adv_more;
    logic             w_adv_finish;

    // Block position of the current byte
    always_comb begin
        case (r_phase)
            PH_VER_HI: w_pos = '0;
            PH_VER_LO: w_pos = POS_W'(1);
            PH_BYTE:   w_pos = POS_W'(r_offset) + POS_W'(2);
            PH_CRC_HI: w_pos = POS_CRC_HI;
            PH_CRC_LO: w_pos = POS_CRC_LO;
            default:   w_pos = '0;
        endcase
    end

    assign w_emit    = (w_pos[1:0] == 2'b11) || (w_pos == POS_CRC_LO);
    assign w_full    = (r_offset == OFF_LAST);
    assign w_off_new = (r_phase == PH_BYTE) ? (w_full ? '0 : r_offset + OFF_W'(1)) : r_offset;

    // Stream byte count and end detection for the next accepted item
    assign w_cnt_inc = {1'b0, r_count} + (LEN_W + 1)'(1);
    assign w_cnt_end = (w_cnt_inc >= {1'b0, i_stat.eff_len});

    // Pick the stream byte that follows the current one
    always_comb begin
        w_adv_src    = r_src;
        w_adv_more   = 1'b1;
        w_adv_finish = 1'b0;
        case (r_src)
            SRC_HDR0: w_adv_src = SRC_HDR1;
            SRC_HDR1: w_adv_src = SRC_HDR2;
            SRC_HDR2: w_adv_src = SRC_HDR3;
            SRC_HDR3: w_adv_src = SRC_DATA;
            SRC_DATA: begin
                w_adv_src  = SRC_CRC0;
                w_adv_more = r_end;
            end
            SRC_CRC0: w_adv_src = SRC_CRC1;
            SRC_CRC1: w_adv_src = SRC_CRC2;
            SRC_CRC2: w_adv_src = SRC_CRC3;
            SRC_CRC3, SRC_PAD: begin
                w_adv_src    = SRC_PAD;
                w_adv_more   = (w_off_new != '0);
                w_adv_finish = (w_off_new == '0);
            end
            default: w_adv_more = 1'b0;
        endcase
    end

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_src    = r_src;
        n_phase  = r_phase;
        n_offset = r_offset;
        n_count  = r_count;
        n_failed = r_failed;
        n_end    = r_end;

        s_axis_tready    = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.step       = 1'b0;
        o_cmd.src        = r_src;
        o_cmd.phase      = r_phase;
        o_cmd.pos        = w_pos;
        o_cmd.emit       = w_emit;
        o_cmd.eos        = w_emit && (r_phase == PH_CRC_LO)
                           && ((r_src == SRC_CRC3) || (r_src == SRC_PAD));
        o_cmd.err        = 1'b0;
        o_cmd.stream_end = 1'b0;

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_end      = w_cnt_end;
                    n_count    = w_cnt_end ? '0 : w_cnt_inc[LEN_W-1:0];
                    if ((r_count == '0) && i_stat.too_large) begin
                        n_state = ST_ERROR;
                    end else if (r_failed) begin
                        // drop the byte; close the failed stream on its last byte
                        if (w_cnt_end) begin
                            n_failed         = 1'b0;
                            o_cmd.stream_end = 1'b1;
                        end
                    end else begin
                        n_src   = (r_count == '0) ? SRC_HDR0 : SRC_DATA;
                        n_phase = (r_offset == '0) ? PH_VER_HI : PH_BYTE;
                        n_state = ST_STEP;
                    end
                end
            end

            ST_ERROR: begin
                if (i_stat.out_free) begin
                    o_cmd.err = 1'b1;
                    n_state   = ST_IDLE;
                    if (r_end) begin
                        n_failed         = 1'b0;
                        o_cmd.stream_end = 1'b1;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
            end

            ST_STEP: begin
                // hold while a finished word cannot be handed over
                if (!w_emit || i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    case (r_phase)
                        PH_VER_HI: n_phase = PH_VER_LO;
                        PH_VER_LO: n_phase = PH_BYTE;
                        PH_CRC_HI: n_phase = PH_CRC_LO;
                        default: begin
                            if (r_phase == PH_BYTE) begin
                                n_offset = w_off_new;
                            end
                            if ((r_phase == PH_BYTE) && w_full) begin
                                n_phase = PH_CRC_HI;
                            end else if (w_adv_more) begin
                                n_src   = w_adv_src;
                                n_phase = (w_off_new == '0) ? PH_VER_HI : PH_BYTE;
                            end else begin
                                n_state = ST_IDLE;
                                if (w_adv_finish) begin
                                    n_offset         = '0;
                                    o_cmd.stream_end = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_src    <= SRC_HDR0;
            r_phase  <= PH_VER_HI;
            r_offset <= '0;
            r_count  <= '0;
            r_failed <= 1'b0;
            r_end    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_src    <= n_src;
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_count  <= n_count;
            r_failed <= n_failed;
            r_end    <= n_end;
        end
    end

    `VBSF_ASSERT_SAME(a_emit_has_room, o_cmd.step && o_cmd.emit, i_stat.out_free,
        "word placed while output register is full")
    `VBSF_ASSERT_SAME(a_eos_closes_stream, o_cmd.step && o_cmd.eos, o_cmd.stream_end,
        "last stream word without stream close")
    `VBSF_ASSERT_NEXT(a_close_to_idle, o_cmd.stream_end,
        (r_state == ST_IDLE) && (r_offset == '0) && (r_count == '0),
        "stream close left sequencer busy or mid-block")

endmodule

// ===== design/vbsf_dp.sv =====
// ----------------------------------------------------------------------------
// vbsf_dp
// Datapath: configuration registers, CRC-32 and CRC-16 engines, word
// assembly, block index arithmetic and the output register.
// ----------------------------------------------------------------------------
`include "versioned_block_stream_framer_unit_defines.svh"

module vbsf_dp import vbsf_pkg::*; #(
    parameter int unsigned DATA_BYTES_PER_BLOCK = DATA_BYTES_PER_BLOCK_DEF,
    parameter int unsigned NUM_BLOCKS           = NUM_BLOCKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tready,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    output logic [BIDX_W-1:0]     o_out_bidx,
    output logic [WIDX_W-1:0]     o_out_widx,
    output logic [WORD_W-1:0]     o_out_word,
    output logic                  o_out_eos,
    output logic                  o_out_tl
);

    localparam int unsigned BD_W      = $clog2(NUM_BLOCKS);
    localparam int unsigned MAX_TOTAL = DATA_BYTES_PER_BLOCK * (NUM_BLOCKS / 2);
    localparam logic [BD_W-1:0] BD_LAST = BD_W'(NUM_BLOCKS - 1);

    logic [LEN_W-1:0]   r_len;
    logic [VER_W-1:0]   r_version;
    logic [START_W-1:0] r_start;
    logic [7:0]         r_byte;
    logic [31:0]        r_stream_crc;
    logic [15:0]        r_block_crc;
    logic [31:0]        r_ws;
    logic [BD_W-1:0]    r_blocks_done;

    logic               r_out_valid;
    logic [BIDX_W-1:0]  r_out_bidx;
    logic [WIDX_W-1:0]  r_out_widx;
    logic [WORD_W-1:0]  r_out_word;
    logic               r_out_eos;
    logic               r_out_tl;

    logic [LEN_W-1:0]   w_eff_len;
    logic [LEN_W:0]     w_total;
    logic [31:0]        w_crc_out;
    logic [7:0]         w_byte;
    logic               w_crc32_upd;
    logic               w_crc16_upd;
    logic [31:0]        w_ws_new;
    logic [31:0]        w_word;
    logic [BD_W-1:0]    w_smod_tab [START_BLOCKS];
    logic [BD_W:0]      w_bsum;
    logic [BD_W-1:0]    w_bidx;
    logic               w_out_load;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_W'(1);
            r_version <= '0;
            r_start   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_PAYLOAD_LENGTH: r_len     <= i_cfg_data[LEN_W-1:0];
                CFG_STREAM_VERSION: r_version <= i_cfg_data[VER_W-1:0];
                CFG_START_BLOCK:    r_start   <= i_cfg_data[START_W-1:0];
                default: ;
            endcase
        end
    end

    // Length header and size check
    assign w_eff_len = (r_len == '0) ? LEN_W'(1) : r_len;
    assign w_total   = {1'b0, w_eff_len} + FRAME_OVERHEAD;
    assign w_crc_out = ~r_stream_crc;

    assign o_stat.eff_len   = w_eff_len;
    assign o_stat.too_large = (32'(w_total) > MAX_TOTAL);
    assign o_stat.out_free  = !r_out_valid || m_axis_tready;

    // Select the block byte
    always_comb begin
        case (i_cmd.phase)
            PH_VER_HI: w_byte = r_version[15:8];
            PH_VER_LO: w_byte = r_version[7:0];
            PH_CRC_HI: w_byte = r_block_crc[15:8];
            PH_CRC_LO: w_byte = r_block_crc[7:0];
            default: begin
                case (i_cmd.src)
                    SRC_HDR2: w_byte = 8'(w_total >> 8);
                    SRC_HDR3: w_byte = w_total[7:0];
                    SRC_DATA: w_byte = r_byte;
                    SRC_CRC0: w_byte = w_crc_out[31:24];
                    SRC_CRC1: w_byte = w_crc_out[23:16];
                    SRC_CRC2: w_byte = w_crc_out[15:8];
                    SRC_CRC3: w_byte = w_crc_out[7:0];
                    default:  w_byte = 8'h00;
                endcase
            end
        endcase
    end

    assign w_crc32_upd = (i_cmd.phase == PH_BYTE)
                         && ((i_cmd.src == SRC_HDR0) || (i_cmd.src == SRC_HDR1)
                             || (i_cmd.src == SRC_HDR2) || (i_cmd.src == SRC_HDR3)
                             || (i_cmd.src == SRC_DATA));
    assign w_crc16_upd = (i_cmd.phase == PH_VER_HI) || (i_cmd.phase == PH_VER_LO)
                         || (i_cmd.phase == PH_BYTE);

    // Word assembly: left-align a short last word
    assign w_ws_new = {r_ws[23:0], w_byte};
    assign w_word   = w_ws_new << {~i_cmd.pos[1:0], 3'b000};

    // Start block reduced modulo block count, one entry per start value
    for (genvar g = 0; g < START_BLOCKS; g++) begin : g_smod
        localparam int unsigned SMOD = g % NUM_BLOCKS;
        assign w_smod_tab[g] = BD_W'(SMOD);
    end

    assign w_bsum = {1'b0, w_smod_tab[r_start]} + {1'b0, r_blocks_done};
    assign w_bidx = (w_bsum >= (BD_W + 1)'(NUM_BLOCKS))
                    ? BD_W'(w_bsum - (BD_W + 1)'(NUM_BLOCKS)) : w_bsum[BD_W-1:0];

    // Latch the accepted byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= s_axis_tdata;
        end
    end

    // Stream and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_crc  <= CRC32_INIT;
            r_block_crc   <= CRC16_INIT;
            r_ws          <= '0;
            r_blocks_done <= '0;
        end else if (i_cmd.stream_end) begin
            r_stream_crc  <= CRC32_INIT;
            r_block_crc   <= CRC16_INIT;
            r_ws          <= '0;
            r_blocks_done <= '0;
        end else if (i_cmd.step) begin
            if (w_crc32_upd) begin
                r_stream_crc <= crc32_byte(r_stream_crc, w_byte);
            end
            if (w_crc16_upd) begin
                r_block_crc <= crc16_byte(r_block_crc, w_byte);
            end
            r_ws <= i_cmd.emit ? '0 : w_ws_new;
            // close the block
            if (i_cmd.phase == PH_CRC_LO) begin
                r_block_crc   <= CRC16_INIT;
                r_blocks_done <= (r_blocks_done == BD_LAST) ? '0 : r_blocks_done + BD_W'(1);
            end
        end
    end

    // Output register
    assign w_out_load = (i_cmd.step && i_cmd.emit) || i_cmd.err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err) begin
            r_out_bidx <= '0;
            r_out_widx <= '0;
            r_out_word <= '0;
            r_out_eos  <= 1'b0;
            r_out_tl   <= 1'b1;
        end else if (i_cmd.step && i_cmd.emit) begin
            r_out_bidx <= BIDX_W'(w_bidx);
            r_out_widx <= WIDX_W'(i_cmd.pos >> 2);
            r_out_word <= w_word;
            r_out_eos  <= i_cmd.eos;
            r_out_tl   <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_bidx  = r_out_bidx;
    assign o_out_widx  = r_out_widx;
    assign o_out_word  = r_out_word;
    assign o_out_eos   = r_out_eos;
    assign o_out_tl    = r_out_tl;

    `VBSF_ASSERT_NEXT(a_block_crc_restart,
        i_cmd.step && (i_cmd.phase == PH_CRC_LO), r_block_crc == CRC16_INIT,
        "block CRC not restarted after block close")

endmodule

// ===== design/versioned_block_stream_framer_unit.sv =====
// Usage
// Payload bytes enter on the s_axis channel, one per item. The first byte of a
// stream also pushes the 4-byte length header; the byte that reaches
// payload_length closes the stream, adding the CRC-32, zero padding and the
// final block CRC-16. Results leave on m_axis as 32-bit block words with
// block and word index in tdata, tlast on the last word of a stream and tuser
// set on the single too-large error item.
// Configuration is written through i_cfg_* while no stream byte is in flight;
// register 0 is payload_length, 1 stream_version, 2 start_block.
// The sequencer takes an item only while idle, and no new one until its block
// bytes are placed, one block byte per cycle while the output register has room.
// A payload byte adds 2 version bytes when it opens a block and 2 block CRC bytes
// when it closes one; the first byte adds 4 header bytes and the last 4 CRC bytes,
// padding to the block end and 2 block CRC bytes, plus 2 version bytes when the
// CRC bytes open a new block. A result is registered as its last byte is placed.
// Reset returns the configuration to payload_length 1, version 0, start
// block 0 and restarts the stream. When the receiver stalls, the finished
// word is held in the output register and the sequencer holds at the next
// word-completing byte; the input side stops accepting meanwhile.
// ----------------------------------------------------------------------------
// versioned_block_stream_framer_unit
// Frames a byte stream into versioned, CRC-protected storage block words.
// ----------------------------------------------------------------------------
module versioned_block_stream_framer_unit import vbsf_pkg::*; #(
    parameter int unsigned DATA_BYTES_PER_BLOCK = DATA_BYTES_PER_BLOCK_DEF,
    parameter int unsigned NUM_BLOCKS           = NUM_BLOCKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // payload input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    // block word output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [5:0] block_index, [9:6] word_index,
                                                  // [41:10] block_word, rest zero
    output logic                  m_axis_tlast,   // end_of_stream
    output logic                  m_axis_tuser    // too_large
);

    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [BIDX_W-1:0] w_bidx;
    logic [WIDX_W-1:0] w_widx;
    logic [WORD_W-1:0] w_word;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    vbsf_ctrl #(
        .DATA_BYTES_PER_BLOCK(DATA_BYTES_PER_BLOCK)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    vbsf_dp #(
        .DATA_BYTES_PER_BLOCK(DATA_BYTES_PER_BLOCK),
        .NUM_BLOCKS          (NUM_BLOCKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tready(m_axis_tready),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (m_axis_tvalid),
        .o_out_bidx   (w_bidx),
        .o_out_widx   (w_widx),
        .o_out_word   (w_word),
        .o_out_eos    (m_axis_tlast),
        .o_out_tl     (m_axis_tuser)
    );

    // Pack result fields, lowest field first
    assign m_axis_tdata = {{M_PAD_W{1'b0}}, w_word, w_widx, w_bidx};

endmodule

// ===== tb/vbsf_frame_monitor.sv =====
// ----------------------------------------------------------------------------
// vbsf_frame_monitor
// Watches the configuration, payload and block word channels of the framer.
// Each accepted payload byte is run through a local model of the framing
// (length header, CRC-32 trailer, versioned blocks with CRC-16), and every
// block word it completes is queued. Each block word that leaves the framer
// is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module vbsf_frame_monitor import vbsf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,
    input  logic                  i_m_tlast,
    input  logic                  i_m_tuser,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int BLK_DATA   = DATA_BYTES_PER_BLOCK_DEF;
    localparam int BLK_COUNT  = NUM_BLOCKS_DEF;
    localparam logic [15:0] CCITT_POLY = 16'h1021;
    localparam logic [31:0] ETH_POLY   = 32'hEDB88320;

    typedef struct packed {
        logic [BIDX_W-1:0] blk;
        logic [WIDX_W-1:0] widx;
        logic [WORD_W-1:0] word;
        logic              eos;
        logic              err;
    } t_frame_word;

    t_frame_word       word_fifo[$];

    // register copies
    logic [LEN_W-1:0]   cfg_len;
    logic [VER_W-1:0]   cfg_ver;
    logic [START_W-1:0] cfg_start;

    // framing state
    logic [31:0] str_crc;
    logic [15:0] blk_crc;
    int          pay_cnt;
    int          blk_off;
    int          blks_done;
    logic [31:0] word_acc;
    logic        oversize;

    // CRC-16/CCITT-FALSE, MSB first
    function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
        end
        return c;
    endfunction

    // CRC-32 reflected, LSB first
    function automatic logic [31:0] eth_crc_next(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = (c >> 1) ^ (fb ? ETH_POLY : 32'h0);
        end
        return c;
    endfunction

    // Append one expected word at the tail of the queue
    function automatic void enqueue_word(input t_frame_word fw);
        word_fifo = {word_fifo, fw};
    endfunction

    // Shift one byte into the word at block position pos; queue full words
    function automatic void place_byte(input logic [7:0] b, input int pos);
        t_frame_word fw;
        int          lane;
        lane     = pos % 4;
        word_acc = {word_acc[23:0], b};
        if (lane == 3 || pos == BLK_DATA + 3) begin
            fw.blk   = BIDX_W'((int'(cfg_start) + blks_done) % BLK_COUNT);
            fw.widx  = WIDX_W'(pos / 4);
            fw.word  = word_acc << (8 * (3 - lane));
            fw.eos   = 1'b0;
            fw.err   = 1'b0;
            enqueue_word(fw);
            word_acc = '0;
        end
    endfunction

    // Put one stream byte into the current block, opening and closing it
    function automatic void block_put(input logic [7:0] b);
        if (blk_off == 0) begin
            blk_crc = ccitt_next(blk_crc, cfg_ver[15:8]);
            place_byte(cfg_ver[15:8], 0);
            blk_crc = ccitt_next(blk_crc, cfg_ver[7:0]);
            place_byte(cfg_ver[7:0], 1);
        end
        blk_crc = ccitt_next(blk_crc, b);
        place_byte(b, 2 + blk_off);
        blk_off++;
        if (blk_off >= BLK_DATA) begin
            place_byte(blk_crc[15:8], BLK_DATA + 2);
            place_byte(blk_crc[7:0], BLK_DATA + 3);
            blk_crc   = 16'hFFFF;
            blk_off   = 0;
            blks_done = (blks_done + 1) % BLK_COUNT;
        end
    endfunction

    function automatic void stream_put(input logic [7:0] b);
        str_crc = eth_crc_next(str_crc, b);
        block_put(b);
    endfunction

    function automatic void clear_stream();
        str_crc   = 32'hFFFFFFFF;
        blk_crc   = 16'hFFFF;
        pay_cnt   = 0;
        blk_off   = 0;
        blks_done = 0;
        word_acc  = '0;
        oversize  = 1'b0;
    endfunction

    // Queue every block word that one payload byte completes
    function automatic void frame_payload_byte(input logic [7:0] b);
        int          eff_len;
        int          first_new;
        logic [31:0] total;
        logic [31:0] trailer;
        t_frame_word fw;
        eff_len   = (cfg_len == 0) ? 1 : int'(cfg_len);
        first_new = word_fifo.size();
        // open the stream: length header, or the single error word
        if (pay_cnt == 0) begin
            total = eff_len + 8;
            if ((total + BLK_DATA - 1) / BLK_DATA > BLK_COUNT / 2) begin
                oversize = 1'b1;
                fw       = '0;
                fw.err   = 1'b1;
                enqueue_word(fw);
            end else begin
                stream_put(total[31:24]);
                stream_put(total[23:16]);
                stream_put(total[15:8]);
                stream_put(total[7:0]);
            end
        end
        if (!oversize) begin
            stream_put(b);
        end
        pay_cnt++;
        // close the stream: CRC-32 trailer, zero pad, mark the last word
        if (pay_cnt >= eff_len) begin
            if (!oversize) begin
                trailer = ~str_crc;
                block_put(trailer[31:24]);
                block_put(trailer[23:16]);
                block_put(trailer[15:8]);
                block_put(trailer[7:0]);
                while (blk_off != 0) begin
                    block_put(8'h00);
                end
                if (word_fifo.size() > first_new) begin
                    word_fifo[word_fifo.size() - 1].eos = 1'b1;
                end
            end
            clear_stream();
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    // Track register writes, predict on payload items, compare block words
    always @(posedge i_clk) begin : watch
        t_frame_word want;
        if (!i_rst_n) begin
            cfg_len   = 11'd1;
            cfg_ver   = '0;
            cfg_start = '0;
            clear_stream();
            word_fifo.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_addr))
                    CFG_PAYLOAD_LENGTH: cfg_len   = i_cfg_data[LEN_W-1:0];
                    CFG_STREAM_VERSION: cfg_ver   = i_cfg_data[VER_W-1:0];
                    CFG_START_BLOCK:    cfg_start = i_cfg_data[START_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                frame_payload_byte(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (word_fifo.size() == 0) begin
                    $error("block word 0x%0h arrived with no word expected", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = word_fifo.pop_front();
                    check_field("block_index", 32'(want.blk), 32'(i_m_tdata[BIDX_W-1:0]));
                    check_field("word_index", 32'(want.widx),
                                32'(i_m_tdata[BIDX_W +: WIDX_W]));
                    check_field("block_word", want.word,
                                i_m_tdata[BIDX_W + WIDX_W +: WORD_W]);
                    check_field("end_of_stream", 32'(want.eos), 32'(i_m_tlast));
                    check_field("too_large", 32'(want.err), 32'(i_m_tuser));
                end
            end
        end
        o_pending = word_fifo.size();
    end

endmodule

// ===== tb/versioned_block_stream_framer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// versioned_block_stream_framer_unit_tb
// Drives payload streams of many lengths and settings into the framer and
// lets the frame monitor check every block word. A short directed part covers
// tiny streams, zero length and extreme versions and start blocks; random
// streams follow under three idling mixes, with a long receiver hold-off,
// pauses until the output drains, too-large streams and long streams that
// a length drop cuts short.
// ----------------------------------------------------------------------------
module versioned_block_stream_framer_unit_tb;
    import vbsf_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 70;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    int   fail_count;
    int   pending_words;
    int   cycle_cnt     = 0;
    int   items_sent    = 0;
    int   frame_len     = 1;
    int   send_idle_pct = 13;
    int   recv_idle_pct = 83;
    int   hold_left     = 0;
    logic hold_req      = 1'b0;
    logic hold_ack      = 1'b0;

    always #5 i_clk = ~i_clk;

    versioned_block_stream_framer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    vbsf_frame_monitor u_frame_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Write one register; valid stays high for a following write
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Write the registers selected by mask (length, version, start block)
    task automatic set_framing(input logic [2:0] mask, input int len, input int ver,
                               input int start);
        if (mask[0]) begin
            write_reg(CFG_PAYLOAD_LENGTH, CFG_DATA_W'(len));
            frame_len = (len == 0) ? 1 : len;
        end
        if (mask[1]) begin
            write_reg(CFG_STREAM_VERSION, CFG_DATA_W'(ver));
        end
        if (mask[2]) begin
            write_reg(CFG_START_BLOCK, CFG_DATA_W'(start));
        end
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one payload item after a random gap; valid stays high
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    // Send one stream of n bytes; fill < 0 means random bytes.
    // Before byte pause_at, hold the input until all words have drained.
    task automatic send_stream(input int n, input int pause_at, input int fill);
        for (int i = 0; i < n; i++) begin
            if (i == pause_at) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
                while (pending_words != 0) begin
                    @(negedge i_clk);
                end
            end
            send_byte((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
        end
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait for the output to drain and the framer to go quiet
    task automatic settle();
        while (pending_words != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int          phase_start;
        int          pause_at;
        int          len;
        int          ver;
        int          start;
        int          pick;
        logic [2:0]  mask;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: tiny streams, zero length, extreme versions and start blocks
        set_framing(3'b111, 1, 0, 0);
        send_stream(1, -1, 8'h00);
        settle();
        set_framing(3'b111, 0, 16'hFFFF, 63);
        send_stream(1, -1, 8'hFF);
        settle();
        set_framing(3'b101, 2, 0, 62);
        send_stream(2, -1, -1);
        settle();
        set_framing(3'b111, 3, 16'h00FF, 63);
        send_stream(3, -1, 8'h5A);
        settle();
        set_framing(3'b011, 16, 16'hFF00, 0);
        send_stream(16, 8, 8'hA5);
        settle();

        // Random streams under three idling mixes
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 13 : (p == 1) ? 83 : 0;
            recv_idle_pct = (p == 0) ? 83 : (p == 1) ? 13 : 0;

            // long receiver hold-off while payload keeps coming
            if (p == 0) begin
                set_framing(3'b001, 40, 0, 0);
                hold_req = ~hold_req;
                send_stream(40, -1, -1);
                settle();
            end

            // smallest too-large stream, paused partway, ended by a length drop
            if (p == 1) begin
                set_framing(3'b111, 1913, $urandom_range(65535), $urandom_range(63));
                send_stream(6, 3, -1);
                settle();
                set_framing(3'b001, 1, 0, 0);
                send_stream(1, -1, -1);
                settle();
            end

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                mask  = 3'($urandom_range(1, 7));
                pick  = $urandom_range(99);
                if (pick < 60) begin
                    len = $urandom_range(1, 40);
                end else if (pick < 80) begin
                    case ($urandom_range(5))
                        0:       len = 52;
                        1:       len = 53;
                        2:       len = 112;
                        3:       len = 113;
                        4:       len = 0;
                        default: len = 4;
                    endcase
                end else begin
                    len = $urandom_range(41, 150);
                end
                ver   = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 0 : 16'hFFFF)
                                                 : $urandom_range(65535);
                start = ($urandom_range(3) == 0) ? 63 : $urandom_range(63);
                set_framing(mask, len, ver, start);
                pause_at = ($urandom_range(4) == 0) ? $urandom_range(frame_len - 1) : -1;
                send_stream(frame_len, pause_at, -1);
                settle();
            end

            // largest stream that fits and the largest length overall, each cut
            // short by dropping the length below the bytes already taken
            if (p == 2) begin
                set_framing(3'b111, 1912, $urandom_range(65535), 40);
                send_stream(70, -1, -1);
                settle();
                set_framing(3'b001, 1, 0, 0);
                send_stream(1, -1, -1);
                settle();
                set_framing(3'b001, 2047, 0, 0);
                send_stream(4, -1, -1);
                settle();
                set_framing(3'b001, 2, 0, 0);
                send_stream(1, -1, -1);
                settle();
            end
        end

        if (fail_count == 0 && pending_words == 0) begin
            $display("Regression PASS");
        end else begin
            if (pending_words != 0) begin
                $error("%0d expected block words never arrived", pending_words);
            end
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
